>>> src/xoshiro_bounded_random_generator_unit_defines.svh
// assertion macros shared by the generator modules
`ifndef XOSHIRO_BOUNDED_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO_BOUNDED_RANDOM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define XBRG_ASSERT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define XBRG_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define XBRG_ASSERT(lbl, clk_sig, rst_sig, ante, cons)
`define XBRG_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons)
`endif

`endif

>>> src/xbrg_pkg.sv
package xbrg_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned FRAC_SHIFT = 11;
	localparam int unsigned STATE_SHIFT = 17;
	localparam int unsigned STATE_ROT = 45;
	localparam int unsigned OUT_ROT = 7;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_ONE = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_TWO = 64'h94D0_49BB_1331_11EB;

	localparam logic [1:0] LAST_WORD = 2'd3;

	typedef enum logic [1:0] {
		OP_RESEED  = 2'd0,
		OP_RAW     = 2'd1,
		OP_BOUNDED = 2'd2,
		OP_FRAC    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_RAW,
		RES_FRAC,
		RES_BOUNDED
	} res_sel_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LL,
		MUL_HL,
		MUL_LH
	} mul_phase_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SM_ADD,
		ST_MUL_LL,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_MIX,
		ST_STORE,
		ST_FIXZ,
		ST_SPAN,
		ST_MASK,
		ST_DRAW,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       ctr_load;
		logic       ctr_zero;
		logic       sm_add;
		mul_phase_t mul;
		logic       mul_c2;
		logic       mix27;
		logic       store;
		logic       fix_zero;
		logic       span;
		logic       mask;
		logic       draw;
		logic       res_load;
		res_sel_t   res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic pick_ok;
		logic res_busy;
	} dp_sts_t;

endpackage

>>> src/xbrg_dpath.sv
`include "xoshiro_bounded_random_generator_unit_defines.svh"

module xbrg_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  xbrg_pkg::dp_cmd_t   cmd,
	output xbrg_pkg::dp_sts_t   sts,
	input  logic signed [63:0]  value_a,
	input  logic signed [63:0]  value_b,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         result_value
);

	logic [63:0] s0_q, s1_q, s2_q, s3_q;
	logic [63:0] ctr_q, z_q, acc_q;
	logic [63:0] lo_q, hi_q, span_q, mask_q, word_q;
	logic [63:0] result_q;
	logic        out_valid_q;

	logic [63:0] ctr_next, coef;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] x5, x5_rot, draw_out;
	logic [63:0] n0, n1, n2, n3;
	logic [63:0] mask_m1, smear;
	logic [63:0] pick;
	logic        pick_ok;
	logic [63:0] res_d;

	assign ctr_next = ctr_q + xbrg_pkg::GOLDEN_GAMMA;

	// one shared 32x32 multiplier builds the low 64 bits from the LL, HL and LH partial products
	assign coef  = cmd.mul_c2 ? xbrg_pkg::MIX_MUL_TWO : xbrg_pkg::MIX_MUL_ONE;
	assign mul_a = (cmd.mul == xbrg_pkg::MUL_HL) ? z_q[63:32] : z_q[31:0];
	assign mul_b = (cmd.mul == xbrg_pkg::MUL_LH) ? coef[63:32] : coef[31:0];
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	// output scrambler: rotl(s1 * 5, 7) * 9 as shift-adds
	assign x5       = s1_q + (s1_q << 2);
	assign x5_rot   = (x5 << xbrg_pkg::OUT_ROT) | (x5 >> (xbrg_pkg::WORD_W - xbrg_pkg::OUT_ROT));
	assign draw_out = x5_rot + (x5_rot << 3);

	assign n2 = s2_q ^ s0_q;
	assign n3 = s3_q ^ s1_q;
	assign n1 = s1_q ^ n2;
	assign n0 = s0_q ^ n3;

	always_comb begin
		mask_m1 = span_q - 64'd1;
		smear   = mask_m1;
		smear   = smear | (smear >> 1);
		smear   = smear | (smear >> 2);
		smear   = smear | (smear >> 4);
		smear   = smear | (smear >> 8);
		smear   = smear | (smear >> 16);
		smear   = smear | (smear >> 32);
	end

	// a zero span stands for the full 64-bit range
	assign pick    = word_q & mask_q;
	assign pick_ok = (span_q == 64'd0) || (pick < span_q);

	always_comb begin
		case (cmd.res_sel)
			xbrg_pkg::RES_ZERO:    res_d = 64'd0;
			xbrg_pkg::RES_RAW:     res_d = draw_out;
			xbrg_pkg::RES_FRAC:    res_d = draw_out >> xbrg_pkg::FRAC_SHIFT;
			xbrg_pkg::RES_BOUNDED: res_d = lo_q + pick;
			default:               res_d = 64'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lo_q <= $unsigned(value_a);
			hi_q <= $unsigned(value_b);
		end
		if (cmd.ctr_load) begin
			ctr_q <= cmd.ctr_zero ? 64'd0 : $unsigned(value_a);
		end else if (cmd.sm_add) begin
			ctr_q <= ctr_next;
		end
		if (cmd.sm_add) begin
			z_q <= ctr_next ^ (ctr_next >> 30);
		end else if (cmd.mix27) begin
			z_q <= acc_q ^ (acc_q >> 27);
		end
		if (cmd.mul == xbrg_pkg::MUL_LL) begin
			acc_q <= prod;
		end else if (cmd.mul != xbrg_pkg::MUL_NONE) begin
			acc_q <= acc_q + {prod[31:0], 32'd0};
		end
		// seeding shifts words in so the first one ends up in s0
		if (cmd.store) begin
			s0_q <= s1_q;
			s1_q <= s2_q;
			s2_q <= s3_q;
			s3_q <= acc_q ^ (acc_q >> 31);
		end else if (cmd.fix_zero) begin
			if ((s0_q | s1_q | s2_q | s3_q) == 64'd0) begin
				s0_q <= xbrg_pkg::GOLDEN_GAMMA;
			end
		end else if (cmd.draw) begin
			s0_q <= n0;
			s1_q <= n1;
			s2_q <= n2 ^ (s1_q << xbrg_pkg::STATE_SHIFT);
			s3_q <= (n3 << xbrg_pkg::STATE_ROT) |
				(n3 >> (xbrg_pkg::WORD_W - xbrg_pkg::STATE_ROT));
		end
		if (cmd.draw) begin
			word_q <= draw_out;
		end
		if (cmd.span) begin
			span_q <= hi_q - lo_q + 64'd1;
		end
		if (cmd.mask) begin
			mask_q <= smear;
		end
		if (cmd.res_load) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign sts.pick_ok  = pick_ok;
	assign sts.res_busy = out_valid_q && !out_ready;

	`XBRG_ASSERT_NEXT(a_fix_nonzero, clk, arst_n, cmd.fix_zero, (s0_q | s1_q | s2_q | s3_q) != 64'd0)
	`XBRG_ASSERT_NEXT(a_mask_covers, clk, arst_n, cmd.mask, mask_q >= (span_q - 64'd1))
	`XBRG_ASSERT(a_pick_in_span, clk, arst_n, cmd.res_load && cmd.res_sel == xbrg_pkg::RES_BOUNDED && span_q != 64'd0, pick < span_q)

endmodule

>>> src/xbrg_ctrl.sv
`include "xoshiro_bounded_random_generator_unit_defines.svh"

module xbrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	output xbrg_pkg::dp_cmd_t cmd,
	input  xbrg_pkg::dp_sts_t sts
);

	xbrg_pkg::state_t  state_q, state_d;
	xbrg_pkg::opcode_t op_q, op_d;
	logic              pass_q, pass_d;
	logic [1:0]        cnt_q, cnt_d;
	logic              init_q, init_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xbrg_pkg::ST_INIT;
			op_q    <= xbrg_pkg::OP_RESEED;
			pass_q  <= 1'b0;
			cnt_q   <= 2'd0;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			pass_q  <= pass_d;
			cnt_q   <= cnt_d;
			init_q  <= init_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		pass_d      = pass_q;
		cnt_d       = cnt_q;
		init_d      = init_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul     = xbrg_pkg::MUL_NONE;
		cmd.res_sel = xbrg_pkg::RES_ZERO;
		case (state_q)
			// after reset the state is seeded from zero before any transaction
			xbrg_pkg::ST_INIT: begin
				cmd.ctr_load = 1'b1;
				cmd.ctr_zero = 1'b1;
				state_d      = xbrg_pkg::ST_SM_ADD;
			end
			xbrg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					op_d        = xbrg_pkg::opcode_t'(opcode);
					case (xbrg_pkg::opcode_t'(opcode))
						xbrg_pkg::OP_RESEED: begin
							cmd.ctr_load = 1'b1;
							state_d      = xbrg_pkg::ST_SM_ADD;
						end
						xbrg_pkg::OP_BOUNDED: state_d = xbrg_pkg::ST_SPAN;
						default:              state_d = xbrg_pkg::ST_DRAW;
					endcase
				end
			end
			xbrg_pkg::ST_SM_ADD: begin
				cmd.sm_add = 1'b1;
				state_d    = xbrg_pkg::ST_MUL_LL;
			end
			xbrg_pkg::ST_MUL_LL: begin
				cmd.mul    = xbrg_pkg::MUL_LL;
				cmd.mul_c2 = pass_q;
				state_d    = xbrg_pkg::ST_MUL_HL;
			end
			xbrg_pkg::ST_MUL_HL: begin
				cmd.mul    = xbrg_pkg::MUL_HL;
				cmd.mul_c2 = pass_q;
				state_d    = xbrg_pkg::ST_MUL_LH;
			end
			xbrg_pkg::ST_MUL_LH: begin
				cmd.mul    = xbrg_pkg::MUL_LH;
				cmd.mul_c2 = pass_q;
				state_d    = pass_q ? xbrg_pkg::ST_STORE : xbrg_pkg::ST_MIX;
			end
			xbrg_pkg::ST_MIX: begin
				cmd.mix27 = 1'b1;
				pass_d    = 1'b1;
				state_d   = xbrg_pkg::ST_MUL_LL;
			end
			xbrg_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				pass_d    = 1'b0;
				cnt_d     = cnt_q + 2'd1;
				state_d   = (cnt_q == xbrg_pkg::LAST_WORD) ? xbrg_pkg::ST_FIXZ :
					xbrg_pkg::ST_SM_ADD;
			end
			xbrg_pkg::ST_FIXZ: begin
				// the zero fix is idempotent, so holding here while stalled is safe
				cmd.fix_zero = 1'b1;
				if (init_q) begin
					init_d  = 1'b0;
					state_d = xbrg_pkg::ST_IDLE;
				end else if (!sts.res_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = xbrg_pkg::RES_ZERO;
					state_d      = xbrg_pkg::ST_IDLE;
				end
			end
			xbrg_pkg::ST_SPAN: begin
				cmd.span = 1'b1;
				state_d  = xbrg_pkg::ST_MASK;
			end
			xbrg_pkg::ST_MASK: begin
				cmd.mask = 1'b1;
				state_d  = xbrg_pkg::ST_DRAW;
			end
			xbrg_pkg::ST_DRAW: begin
				if (op_q == xbrg_pkg::OP_BOUNDED) begin
					cmd.draw = 1'b1;
					state_d  = xbrg_pkg::ST_CHECK;
				end else if (!sts.res_busy) begin
					cmd.draw     = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = (op_q == xbrg_pkg::OP_FRAC) ? xbrg_pkg::RES_FRAC :
						xbrg_pkg::RES_RAW;
					state_d      = xbrg_pkg::ST_IDLE;
				end
			end
			xbrg_pkg::ST_CHECK: begin
				if (!sts.pick_ok) begin
					state_d = xbrg_pkg::ST_DRAW;
				end else if (!sts.res_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = xbrg_pkg::RES_BOUNDED;
					state_d      = xbrg_pkg::ST_IDLE;
				end
			end
			default: state_d = xbrg_pkg::ST_IDLE;
		endcase
	end

	`XBRG_ASSERT(a_no_overwrite, clk, arst_n, cmd.res_load, !sts.res_busy)
	`XBRG_ASSERT_NEXT(a_reseed_start, clk, arst_n, in_valid && in_ready && opcode == xbrg_pkg::OP_RESEED, state_q == xbrg_pkg::ST_SM_ADD)
	`XBRG_ASSERT_NEXT(a_last_store, clk, arst_n, cmd.store && cnt_q == xbrg_pkg::LAST_WORD, state_q == xbrg_pkg::ST_FIXZ && cnt_q == 2'd0)

endmodule

>>> src/xoshiro_bounded_random_generator_unit.sv
// xoshiro256** random generator with splitmix64 seeding. Each accepted
// transaction yields exactly one result: opcode 0 reseeds from value_a and
// returns zero, 1 returns the next raw 64-bit word, 2 returns a uniform
// integer in [value_a, value_b] (signed bounds, span taken modulo 2^64, a
// wrapped span of zero meaning the full range), 3 returns the top 53 bits
// of the next word. A raw or fraction request draws one word and loads
// it into the output register once that register is free. A bounded
// request forms the span and mask, then draws until a masked word falls
// in the span (fewer than two draws on average). A reseed is paced by the
// single shared 32x32 multiplier that forms each of the eight 64-bit
// splitmix products in three passes. After reset the block runs the same
// seeding with seed zero before its first transaction. A finished result
// waits in an output register while the next transaction is accepted.
module xoshiro_bounded_random_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [63:0] value_a,
	input  logic signed [63:0] value_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        result_value
);

	xbrg_pkg::dp_cmd_t cmd;
	xbrg_pkg::dp_sts_t sts;

	xbrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.cmd      (cmd),
		.sts      (sts)
	);

	xbrg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value_a      (value_a),
		.value_b      (value_b),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

endmodule
